FILE: rtl/core/touch_sample_filter_core_assert.svh
// Assertion macros shared by the touch sample filter checkers.
// No dependencies; include by bare file name.
`ifndef TOUCH_SAMPLE_FILTER_CORE_ASSERT_SVH
`define TOUCH_SAMPLE_FILTER_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TSF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("touch filter check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define TSF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("touch filter check failed");

`endif

FILE: rtl/core/tsf_pkg.sv
// Shared types, constants and weight tables of the touch sample filter.
// No dependencies; used by every module of the block but tsf_div.
package tsf_pkg;

   localparam int COORD_BITS   = 12;
   localparam int BATCH_MAX_DEF = 4;
   localparam int HIST_W       = 2;
   localparam int FILL_W       = 3;
   localparam int THR_W        = 13;
   localparam int WT_W         = 4;
   localparam int SH_W         = 3;
   localparam int ACC_W        = COORD_BITS + WT_W;
   localparam int DIST_W       = COORD_BITS + 1;
   localparam int ADDR_W       = 3;
   localparam int DATA_W       = 32;
   localparam int CMP_W        = (DIST_W > THR_W) ? DIST_W : THR_W;

   localparam logic [THR_W-1:0]  THR_RESET  = 13'd100;
   localparam logic [FILL_W-1:0] HIST_DEPTH = 3'd4;

   localparam logic CSR_IDX_THR = 1'b0;
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_PENUP  = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [COORD_BITS-1:0] sample_x;
      logic [COORD_BITS-1:0] sample_y;
      logic                  last_in_batch;
   } req_item_type;

   typedef struct packed {
      logic                  touching;
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic [FILL_W-1:0]     history_used;
   } rsp_item_type;

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_SUM       = 11'b000_0000_0010,
      ST_MEAN      = 11'b000_0000_0100,
      ST_MEAN_WAIT = 11'b000_0000_1000,
      ST_SRCH      = 11'b000_0001_0000,
      ST_DROP      = 11'b000_0010_0000,
      ST_DROP_WAIT = 11'b000_0100_0000,
      ST_PUSH      = 11'b000_1000_0000,
      ST_WSUM      = 11'b001_0000_0000,
      ST_AVG       = 11'b010_0000_0000,
      ST_SEND      = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic store;
      logic batch_begin;
      logic pen_clear;
      logic sum_step;
      logic div_start;
      logic div_drop;
      logic take_mean;
      logic srch_step;
      logic push;
      logic wsum_step;
      logic res_avg;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic idx_end;
      logic div_done;
      logic big_batch;
      logic push_single;
      logic wsum_end;
      logic out_free;
   } status_type;

   // Weight of history entry pos (newest first) for a history of fill entries.
   function automatic logic [WT_W-1:0] hist_weight(input logic [FILL_W-1:0] fill,
                                                   input logic [HIST_W-1:0] pos);
      logic [WT_W-1:0] w;
      w = '0;
      case (fill)
         3'd2: begin
            case (pos)
               2'd0:    w = 4'd5;
               2'd1:    w = 4'd3;
               default: w = 4'd0;
            endcase
         end
         3'd3: begin
            case (pos)
               2'd0:    w = 4'd8;
               2'd1:    w = 4'd5;
               2'd2:    w = 4'd3;
               default: w = 4'd0;
            endcase
         end
         3'd4: begin
            case (pos)
               2'd0:    w = 4'd6;
               2'd1:    w = 4'd4;
               default: w = 4'd3;
            endcase
         end
         default: w = 4'd0;
      endcase
      return w;
   endfunction

   // Normalizing shift that goes with the weights above.
   function automatic logic [SH_W-1:0] hist_shift(input logic [FILL_W-1:0] fill);
      logic [SH_W-1:0] sh;
      case (fill)
         3'd2:    sh = 3'd3;
         default: sh = 3'd4;
      endcase
      return sh;
   endfunction

endpackage

FILE: rtl/core/tsf_div.sv
// Two-lane restoring divider, one quotient bit per cycle for each lane.
// Depends on nothing but its parameters.
module tsf_div #(
   parameter int DVD_W = 14,
   parameter int DVS_W = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dvd_x,
   input  logic [DVD_W-1:0] dvd_y,
   input  logic [DVS_W-1:0] dvs,
   output logic             done,
   output logic [DVD_W-1:0] quo_x,
   output logic [DVD_W-1:0] quo_y
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0]  qx_ff, qx_in, qy_ff, qy_in;
   logic [DVS_W-1:0]  rx_ff, rx_in, ry_ff, ry_in, dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [DVS_W:0]    tx, ty, dx, dy;
   logic              gex, gey;

   always_comb begin
      tx  = {rx_ff, qx_ff[DVD_W-1]};
      ty  = {ry_ff, qy_ff[DVD_W-1]};
      dx  = tx - {1'b0, dvs_ff};
      dy  = ty - {1'b0, dvs_ff};
      gex = tx >= {1'b0, dvs_ff};
      gey = ty >= {1'b0, dvs_ff};

      qx_in   = qx_ff;
      qy_in   = qy_ff;
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;

      if (start) begin
         qx_in   = dvd_x;
         qy_in   = dvd_y;
         rx_in   = '0;
         ry_in   = '0;
         dvs_in  = dvs;
         step_in = STEP_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         qx_in   = {qx_ff[DVD_W-2:0], gex};
         qy_in   = {qy_ff[DVD_W-2:0], gey};
         rx_in   = gex ? dx[DVS_W-1:0] : tx[DVS_W-1:0];
         ry_in   = gey ? dy[DVS_W-1:0] : ty[DVS_W-1:0];
         step_in = step_ff - STEP_W'(1);
         busy_in = step_ff != STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      qx_ff  <= qx_in;
      qy_ff  <= qy_in;
      rx_ff  <= rx_in;
      ry_ff  <= ry_in;
      dvs_ff <= dvs_in;
   end

   assign done  = !busy_ff;
   assign quo_x = qx_ff;
   assign quo_y = qy_ff;

endmodule

FILE: rtl/core/tsf_ctrl.sv
// Sequencer of the touch sample filter: one-hot state machine issuing
// datapath commands. Depends on tsf_pkg.
module tsf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   input  logic                req_last,
   input  tsf_pkg::status_type status,
   output logic                req_ready,
   output tsf_pkg::cmd_type    cmd
);

   tsf_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tsf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == tsf_pkg::KIND_PENUP) begin
                  cmd.pen_clear = 1'b1;
                  state_in      = tsf_pkg::ST_SEND;
               end else begin
                  cmd.store = 1'b1;
                  if (req_last) begin
                     cmd.batch_begin = 1'b1;
                     state_in        = tsf_pkg::ST_SUM;
                  end
               end
            end
         end
         tsf_pkg::ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (status.idx_end) begin
               state_in = tsf_pkg::ST_MEAN;
            end
         end
         tsf_pkg::ST_MEAN: begin
            cmd.div_start = 1'b1;
            state_in      = tsf_pkg::ST_MEAN_WAIT;
         end
         tsf_pkg::ST_MEAN_WAIT: begin
            if (status.div_done) begin
               cmd.take_mean = 1'b1;
               state_in = status.big_batch ? tsf_pkg::ST_SRCH : tsf_pkg::ST_PUSH;
            end
         end
         tsf_pkg::ST_SRCH: begin
            cmd.srch_step = 1'b1;
            if (status.idx_end) begin
               state_in = tsf_pkg::ST_DROP;
            end
         end
         tsf_pkg::ST_DROP: begin
            cmd.div_start = 1'b1;
            cmd.div_drop  = 1'b1;
            state_in      = tsf_pkg::ST_DROP_WAIT;
         end
         tsf_pkg::ST_DROP_WAIT: begin
            if (status.div_done) begin
               state_in = tsf_pkg::ST_PUSH;
            end
         end
         tsf_pkg::ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = status.push_single ? tsf_pkg::ST_SEND : tsf_pkg::ST_WSUM;
         end
         tsf_pkg::ST_WSUM: begin
            cmd.wsum_step = 1'b1;
            if (status.wsum_end) begin
               state_in = tsf_pkg::ST_AVG;
            end
         end
         tsf_pkg::ST_AVG: begin
            cmd.res_avg = 1'b1;
            state_in    = tsf_pkg::ST_SEND;
         end
         tsf_pkg::ST_SEND: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = tsf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/tsf_dp.sv
// Datapath of the touch sample filter: batch store, sums, outlier search,
// history ring, weighted average and result register. Depends on tsf_pkg
// and tsf_div.
module tsf_dp #(
   parameter int BATCH_MAX = tsf_pkg::BATCH_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tsf_pkg::cmd_type              cmd,
   output tsf_pkg::status_type           status,
   input  tsf_pkg::req_item_type         req_item,
   input  logic [tsf_pkg::THR_W-1:0]     thr,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output tsf_pkg::rsp_item_type         rsp_item
);

   localparam int CW    = tsf_pkg::COORD_BITS;
   localparam int CNT_W = $clog2(BATCH_MAX + 1);
   localparam int IDX_W = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
   localparam int SUM_W = CW + IDX_W;
   localparam int HW    = tsf_pkg::HIST_W;
   localparam int FW    = tsf_pkg::FILL_W;
   localparam int AW    = tsf_pkg::ACC_W;
   localparam int DW    = tsf_pkg::DIST_W;
   localparam int KW    = tsf_pkg::CMP_W;

   logic [CW-1:0]    bx_ff [BATCH_MAX];
   logic [CW-1:0]    bx_in [BATCH_MAX];
   logic [CW-1:0]    by_ff [BATCH_MAX];
   logic [CW-1:0]    by_in [BATCH_MAX];
   logic [CW-1:0]    hx_ff [4];
   logic [CW-1:0]    hx_in [4];
   logic [CW-1:0]    hy_ff [4];
   logic [CW-1:0]    hy_in [4];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SUM_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [CW-1:0]    ax_ff, ax_in, ay_ff, ay_in;
   logic [DW-1:0]    dmax_ff, dmax_in;
   logic [CW-1:0]    dropx_ff, dropx_in, dropy_ff, dropy_in;
   logic [HW-1:0]    head_ff, head_in, hidx_ff, hidx_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic [AW-1:0]    accx_ff, accx_in, accy_ff, accy_in;
   tsf_pkg::rsp_item_type res_ff, res_in, rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0]    bsel_x, bsel_y, px, py, hsel_x, hsel_y, prev_x, prev_y;
   logic [SUM_W-1:0] dvd_x, dvd_y, quo_x, quo_y;
   logic [CNT_W-1:0] dvs;
   logic             div_done, jump, push_single;
   logic [DW-1:0]    d_srch, d_jump;
   logic [HW-1:0]    prev, sn;
   logic [FW-1:0]    fill_eff, fill_new;
   logic [tsf_pkg::WT_W-1:0] wt;
   logic [tsf_pkg::SH_W-1:0] sh;
   logic [AW-1:0]    avg_x, avg_y;

   function automatic logic [CW-1:0] absdiff(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   tsf_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .dvd_x (dvd_x),
      .dvd_y (dvd_y),
      .dvs   (dvs),
      .done  (div_done),
      .quo_x (quo_x),
      .quo_y (quo_y)
   );

   always_comb begin
      bsel_x = bx_ff[idx_ff];
      bsel_y = by_ff[idx_ff];
      px     = quo_x[CW-1:0];
      py     = quo_y[CW-1:0];

      dvd_x = cmd.div_drop ? sx_ff - SUM_W'(dropx_ff) : sx_ff;
      dvd_y = cmd.div_drop ? sy_ff - SUM_W'(dropy_ff) : sy_ff;
      dvs   = cmd.div_drop ? cnt_ff - CNT_W'(1) : cnt_ff;

      d_srch = DW'(absdiff(bsel_x, ax_ff)) + DW'(absdiff(bsel_y, ay_ff));

      // jump check against the newest history entry
      prev     = head_ff - HW'(1);
      prev_x   = hx_ff[prev];
      prev_y   = hy_ff[prev];
      d_jump   = DW'(absdiff(px, prev_x)) + DW'(absdiff(py, prev_y));
      jump     = (fill_ff != '0) && (KW'(d_jump) > KW'(thr));
      fill_eff = jump ? '0 : fill_ff;
      fill_new = (fill_eff < tsf_pkg::HIST_DEPTH) ? fill_eff + FW'(1) : fill_eff;
      push_single = fill_new == FW'(1);

      // weighted sum walks from the newest entry backwards
      sn     = head_ff - HW'(1) - hidx_ff;
      hsel_x = hx_ff[sn];
      hsel_y = hy_ff[sn];
      wt     = tsf_pkg::hist_weight(fill_ff, hidx_ff);
      sh     = tsf_pkg::hist_shift(fill_ff);
      avg_x  = accx_ff >> sh;
      avg_y  = accy_ff >> sh;

      status.idx_end     = (CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff;
      status.div_done    = div_done;
      status.big_batch   = (CNT_W+2)'(cnt_ff) >= (CNT_W+2)'(3);
      status.push_single = push_single;
      status.wsum_end    = ({1'b0, hidx_ff} + FW'(1)) == fill_ff;
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      bx_in        = bx_ff;
      by_in        = by_ff;
      hx_in        = hx_ff;
      hy_in        = hy_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      dmax_in      = dmax_ff;
      dropx_in     = dropx_ff;
      dropy_in     = dropy_ff;
      head_in      = head_ff;
      hidx_in      = hidx_ff;
      fill_in      = fill_ff;
      accx_in      = accx_ff;
      accy_in      = accy_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.store && (cnt_ff < CNT_W'(BATCH_MAX))) begin
         bx_in[cnt_ff[IDX_W-1:0]] = req_item.sample_x;
         by_in[cnt_ff[IDX_W-1:0]] = req_item.sample_y;
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.batch_begin) begin
         idx_in = '0;
         sx_in  = '0;
         sy_in  = '0;
      end
      if (cmd.pen_clear) begin
         cnt_in  = '0;
         head_in = '0;
         fill_in = '0;
         res_in  = '0;
      end
      if (cmd.sum_step) begin
         sx_in  = sx_ff + SUM_W'(bsel_x);
         sy_in  = sy_ff + SUM_W'(bsel_y);
         idx_in = status.idx_end ? '0 : idx_ff + IDX_W'(1);
      end
      if (cmd.take_mean) begin
         ax_in = px;
         ay_in = py;
      end
      if (cmd.srch_step) begin
         // keep the earliest sample on ties
         if ((idx_ff == '0) || (d_srch > dmax_ff)) begin
            dmax_in  = d_srch;
            dropx_in = bsel_x;
            dropy_in = bsel_y;
         end
         idx_in = status.idx_end ? '0 : idx_ff + IDX_W'(1);
      end
      if (cmd.push) begin
         hx_in[head_ff] = px;
         hy_in[head_ff] = py;
         head_in = head_ff + HW'(1);
         fill_in = fill_new;
         cnt_in  = '0;
         hidx_in = '0;
         accx_in = '0;
         accy_in = '0;
         if (push_single) begin
            res_in = {1'b1, px, py, FW'(1)};
         end
      end
      if (cmd.wsum_step) begin
         accx_in = accx_ff + AW'(hsel_x) * AW'(wt);
         accy_in = accy_ff + AW'(hsel_y) * AW'(wt);
         hidx_in = hidx_ff + HW'(1);
      end
      if (cmd.res_avg) begin
         res_in = {1'b1, avg_x[CW-1:0], avg_y[CW-1:0], fill_ff};
      end
      if (cmd.out_load) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         idx_ff       <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         hidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         hidx_ff      <= hidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bx_ff    <= bx_in;
      by_ff    <= by_in;
      hx_ff    <= hx_in;
      hy_ff    <= hy_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      dmax_ff  <= dmax_in;
      dropx_ff <= dropx_in;
      dropy_ff <= dropy_in;
      accx_ff  <= accx_in;
      accy_ff  <= accy_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

FILE: rtl/core/touch_sample_filter_core.sv
// Touch sample filter: smooths batches of raw touch samples into position
// reports. Top level joining the controller, datapath and threshold register.
// Depends on tsf_pkg, tsf_ctrl, tsf_dp and tsf_div.
//
// req channel (valid/ready): one item per handshake, a raw sample or a pen-up
// event (kind = 1). A sample with last_in_batch set closes the batch; drop
// samples past BATCH_MAX in a batch. rsp channel (valid/ready): one item per
// closing sample and per pen-up event. APB port: jump threshold at byte
// address 0 (reset value 100).
// A sample that does not close a batch is taken while the sequencer stays
// idle, so such samples go back to back. A closing sample sums the batch and
// divides for the mean; with three samples or more the one farthest from the
// mean is dropped and the rest divided again. The mean enters the history, a
// weighted sum runs if the history holds more than one entry, and the result
// goes to the output register; no new item is taken until then. SUM_W =
// COORD_BITS + log2(BATCH_MAX) is the width of the sum fed to the divider.
// A pen-up event clears the history and goes straight to the send state.
// Reset empties the batch and the history and drops any pending result. A
// stalled receiver holds the result in the output register; the block still
// takes items and stalls only when a second result is ready to go out.
module touch_sample_filter_core #(
   parameter int BATCH_MAX = tsf_pkg::BATCH_MAX_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // input items
   input  logic                               req_valid,
   output logic                               req_ready,
   input  tsf_pkg::req_item_type              req_item,
   // result items
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output tsf_pkg::rsp_item_type              rsp_item,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tsf_pkg::ADDR_W-1:0]         paddr,
   input  logic [tsf_pkg::DATA_W-1:0]         pwdata,
   output logic [tsf_pkg::DATA_W-1:0]         prdata,
   output logic                               pready
);

   tsf_pkg::cmd_type    cmd;
   tsf_pkg::status_type status;

   logic [tsf_pkg::THR_W-1:0] thr_ff, thr_in;
   logic                      reg_idx;
   logic                      wr_en;

   // Register access: word index from the byte address, write on access.
   assign reg_idx = paddr[2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      thr_in = thr_ff;
      prdata = '0;
      unique case (reg_idx)
         tsf_pkg::CSR_IDX_THR: begin
            prdata = tsf_pkg::DATA_W'(thr_ff);
            if (wr_en) begin
               thr_in = pwdata[tsf_pkg::THR_W-1:0];
            end
         end
         default: begin
            // unmapped: read zero, drop writes
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= tsf_pkg::THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // Sequencer: decides what the datapath does each cycle.
   tsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_item.kind),
      .req_last  (req_item.last_in_batch),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // Datapath: batch math, history and output register.
   tsf_dp #(
      .BATCH_MAX (BATCH_MAX)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .thr       (thr_ff),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: rtl/core/tsf_checker.sv
// Port-level checks of the touch sample filter, bound to its top level.
// Depends on tsf_pkg and touch_sample_filter_core_assert.svh.
`include "touch_sample_filter_core_assert.svh"

module tsf_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input tsf_pkg::rsp_item_type      rsp_item,
   input logic                       psel,
   input logic                       penable,
   input logic                       pwrite,
   input logic [tsf_pkg::ADDR_W-1:0] paddr,
   input logic [tsf_pkg::DATA_W-1:0] pwdata,
   input logic [tsf_pkg::DATA_W-1:0] prdata
);

   logic                      rsp_stall, penup_rsp, pos_clear, pos_rsp, used_ok;
   logic                      thr_wr, spare_sel;
   logic [tsf_pkg::THR_W-1:0] thr_rd, thr_wd;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign penup_rsp = rsp_valid && !rsp_item.touching;
   assign pos_clear = (rsp_item.pos_x == '0) && (rsp_item.pos_y == '0) &&
                      (rsp_item.history_used == '0);
   assign pos_rsp   = rsp_valid && rsp_item.touching;
   assign used_ok   = (rsp_item.history_used != '0) &&
                      (rsp_item.history_used <= tsf_pkg::HIST_DEPTH);
   assign spare_sel = paddr[2];
   assign thr_wr    = psel && penable && pwrite && !spare_sel;
   assign thr_rd    = prdata[tsf_pkg::THR_W-1:0];
   assign thr_wd    = pwdata[tsf_pkg::THR_W-1:0];

   // Hold a stalled result unchanged.
   `TSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_item))

   // Pen-up results carry no position and no history count.
   `TSF_ASSERT_SAME(a_penup_zero, clock, reset, penup_rsp, pos_clear)

   // Position reports average one to four history entries.
   `TSF_ASSERT_SAME(a_used_range, clock, reset, pos_rsp, used_ok)

   // A threshold write reads back on the next cycle.
   `TSF_ASSERT_NEXT(a_thr_write, clock, reset, thr_wr, spare_sel || thr_rd == $past(thr_wd))

   // Reset drops any pending result.
   `TSF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind touch_sample_filter_core tsf_checker u_tsf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata)
);
